FILE: hw/rtl/ppi_pkg.sv
// Shared constants and types for the particle pool integrator.
// Pool geometry, request and register codes, and the memory entry layout.
// No dependencies.
`default_nettype none

package ppi_pkg;

    // Pool geometry
    localparam int POOL_SIZE = 64;
    localparam int AW        = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W     = AW + 1;

    // Request kinds
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_EMIT = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Configuration register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_VEL_VAR_X = 2'd0;
    localparam logic [1:0] REG_VEL_VAR_Y = 2'd1;
    localparam logic [1:0] REG_VEL_VAR_Z = 2'd2;

    // One pool slot as kept in memory: life Q9.8, position and velocity Q16.16
    typedef struct packed {
        logic [17:0]      life;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
    } t_entry;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_TICK = 4'b0010,
        S_EMIT = 4'b0100,
        S_READ = 4'b1000
    } t_state;

endpackage : ppi_pkg

`default_nettype wire

FILE: hw/rtl/particle_pool_integrator.sv
// Particle pool integrator top level: slot memory, tick sweep pipeline, emit and read paths.
// Depends on ppi_pkg for pool size, codes and the entry layout.
//
// Usage: a request is taken when start is high and busy is low; each request returns
// exactly one result, shown for a single cycle with o_valid high, and the receiver
// must take it then since it cannot stall. A tick sweeps the pool one slot per cycle
// through the slot memory (read, multiply, write back) and gives its result once the
// sweep has drained. An emit result follows the S_EMIT state, a read result follows
// the S_READ state, and an unused request kind gives its result in the cycle after
// accept. busy stays high from accept until the result beat of a tick, emit or read.
// Configuration registers sit at byte addresses 0, 4 and 8; the user must write them
// only while the block is idle, and the block itself does not enforce this.
`default_nettype none

module particle_pool_integrator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [15:0]        i_amount,
    input  wire logic [5:0]         i_slot,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [31:0] i_vel_x,
    input  wire logic signed [31:0] i_vel_y,
    input  wire logic signed [31:0] i_vel_z,
    input  wire logic [15:0]        i_rand_x,
    input  wire logic [15:0]        i_rand_y,
    input  wire logic [15:0]        i_rand_z,
    // result channel
    output logic                    o_valid,
    output logic [6:0]              o_live_count,
    output logic [5:0]              o_slot_index,
    output logic                    o_is_active,
    output logic signed [17:0]      o_life_left,
    output logic signed [31:0]      o_out_pos_x,
    output logic signed [31:0]      o_out_pos_y,
    output logic signed [31:0]      o_out_pos_z,
    output logic signed [31:0]      o_out_vel_x,
    output logic signed [31:0]      o_out_vel_y,
    output logic signed [31:0]      o_out_vel_z,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    ppi_pkg::t_state r_state;

    logic [15:0] r_var [3];

    logic [ppi_pkg::POOL_SIZE-1:0] r_flags;

    logic [ppi_pkg::AW-1:0]    r_next_slot;
    logic [6:0]                r_live_total;
    logic [ppi_pkg::CNT_W-1:0] r_tick_cnt;

    // captured request
    logic [15:0]            r_amount;
    logic [ppi_pkg::AW-1:0] r_rd_addr;
    logic                   r_rd_in_range;
    logic [5:0]             r_rd_slot;
    logic [31:0]            r_in_pos [3];
    logic [31:0]            r_in_vel [3];
    logic [31:0]            r_jprod  [3];

    // slot memory
    ppi_pkg::t_entry        r_mem [ppi_pkg::POOL_SIZE];
    ppi_pkg::t_entry        r_mem_q;
    logic                   mem_we;
    logic [ppi_pkg::AW-1:0] mem_waddr;
    logic [ppi_pkg::AW-1:0] mem_raddr;
    ppi_pkg::t_entry        mem_wdata;

    // tick sweep pipeline
    logic [ppi_pkg::CNT_W-1:0] r_rd_idx;
    logic                      r_s1_vld;
    logic [ppi_pkg::AW-1:0]    r_s1_idx;
    logic                      r_s2_vld;
    logic [ppi_pkg::AW-1:0]    r_s2_idx;
    ppi_pkg::t_entry           r_s2_entry;
    logic signed [48:0]        r_s2_prod [3];
    logic signed [48:0]        s1_prod   [3];
    logic                      s1_flag;
    logic                      s1_live;
    logic                      sweep_issue;
    logic                      sweep_done;

    // result registers
    logic                   r_valid;
    logic [5:0]             r_res_slot;
    logic                   r_res_active;
    logic [17:0]            r_res_life;
    logic [31:0]            r_res_pos [3];
    logic [31:0]            r_res_vel [3];

    logic accept;
    logic cfg_wr;

    // ------------------------------------------------------------------
    // Handshake and configuration port
    // ------------------------------------------------------------------
    assign busy   = (r_state != ppi_pkg::S_IDLE);
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            ppi_pkg::REG_VEL_VAR_X: prdata = {16'b0, r_var[0]};
            ppi_pkg::REG_VEL_VAR_Y: prdata = {16'b0, r_var[1]};
            ppi_pkg::REG_VEL_VAR_Z: prdata = {16'b0, r_var[2]};
            default:                prdata = 32'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var[0] <= 16'b0;
            r_var[1] <= 16'b0;
            r_var[2] <= 16'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                ppi_pkg::REG_VEL_VAR_X: r_var[0] <= pwdata[15:0];
                ppi_pkg::REG_VEL_VAR_Y: r_var[1] <= pwdata[15:0];
                ppi_pkg::REG_VEL_VAR_Z: r_var[2] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Slot memory: one write port, one registered read port
    // ------------------------------------------------------------------
    assign mem_raddr = (r_state == ppi_pkg::S_IDLE) ? ppi_pkg::AW'(i_slot)
                                                    : r_rd_idx[ppi_pkg::AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[mem_raddr];
    end

    // write mux: emit commit or sweep write-back, never both at once
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_s2_idx;
        mem_wdata = r_s2_entry;
        if (r_state == ppi_pkg::S_EMIT) begin
            mem_we         = 1'b1;
            mem_waddr      = r_next_slot;
            mem_wdata.life = {2'b00, r_amount};
            for (int k = 0; k < 3; k++) begin
                mem_wdata.pos[k] = r_in_pos[k];
                mem_wdata.vel[k] = r_in_vel[k] + {8'b0, r_jprod[k][31:8]};
            end
        end else if (r_s2_vld) begin
            mem_we         = 1'b1;
            mem_wdata.life = r_s2_entry.life - {2'b00, r_amount};
            for (int k = 0; k < 3; k++) begin
                // product is Q24.24; bits [39:8] are the floored Q16.16 step
                mem_wdata.pos[k] = r_s2_entry.pos[k] + r_s2_prod[k][39:8];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sweep stage 1: memory data in hand, decide and multiply
    // ------------------------------------------------------------------
    assign s1_flag = r_flags[r_s1_idx];
    assign s1_live = s1_flag && ($signed(r_mem_q.life) > 18'sd0);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s1_prod[k] = $signed(r_mem_q.vel[k]) * $signed({1'b0, r_amount});
        end
    end

    assign sweep_issue = (r_state == ppi_pkg::S_TICK)
                      && (r_rd_idx != ppi_pkg::CNT_W'(ppi_pkg::POOL_SIZE));
    assign sweep_done  = (r_state == ppi_pkg::S_TICK) && !sweep_issue
                      && !r_s1_vld && !r_s2_vld;

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_idx   <= r_rd_idx[ppi_pkg::AW-1:0];
        r_s2_idx   <= r_s1_idx;
        r_s2_entry <= r_mem_q;
        for (int k = 0; k < 3; k++) begin
            r_s2_prod[k] <= s1_prod[k];
        end
    end

    // ------------------------------------------------------------------
    // Request capture (payload only)
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_amount      <= i_amount;
            r_rd_addr     <= ppi_pkg::AW'(i_slot);
            r_rd_slot     <= i_slot;
            r_rd_in_range <= (int'(i_slot) < ppi_pkg::POOL_SIZE);
            r_in_pos[0]   <= i_pos_x;
            r_in_pos[1]   <= i_pos_y;
            r_in_pos[2]   <= i_pos_z;
            r_in_vel[0]   <= i_vel_x;
            r_in_vel[1]   <= i_vel_y;
            r_in_vel[2]   <= i_vel_z;
            // jitter products, Q8.8 * Q0.16 = Q8.24
            r_jprod[0]    <= r_var[0] * i_rand_x;
            r_jprod[1]    <= r_var[1] * i_rand_y;
            r_jprod[2]    <= r_var[2] * i_rand_z;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer, flags, counters and result beat
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ppi_pkg::S_IDLE;
            r_flags      <= '0;
            r_next_slot  <= '0;
            r_live_total <= 7'b0;
            r_tick_cnt   <= '0;
            r_rd_idx     <= '0;
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_valid  <= 1'b0;
            r_s1_vld <= sweep_issue;
            r_s2_vld <= r_s1_vld && s1_live;

            // sweep stage 1 bookkeeping
            if (r_s1_vld) begin
                if (s1_flag && !s1_live) begin
                    r_flags[r_s1_idx] <= 1'b0;
                end
                if (s1_live) begin
                    r_tick_cnt <= r_tick_cnt + 1'b1;
                end
            end
            if (sweep_issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end

            unique case (r_state)
                ppi_pkg::S_IDLE: begin
                    if (accept) begin
                        unique case (i_req_type)
                            ppi_pkg::REQ_TICK: begin
                                r_rd_idx   <= '0;
                                r_tick_cnt <= '0;
                                r_state    <= ppi_pkg::S_TICK;
                            end
                            ppi_pkg::REQ_EMIT: r_state <= ppi_pkg::S_EMIT;
                            ppi_pkg::REQ_READ: r_state <= ppi_pkg::S_READ;
                            default: begin
                                // unused kind: a plain result beat
                                r_valid      <= 1'b1;
                                r_res_slot   <= 6'b0;
                                r_res_active <= 1'b0;
                                r_res_life   <= 18'b0;
                                for (int k = 0; k < 3; k++) begin
                                    r_res_pos[k] <= 32'b0;
                                    r_res_vel[k] <= 32'b0;
                                end
                            end
                        endcase
                    end
                end
                ppi_pkg::S_TICK: begin
                    if (sweep_done) begin
                        r_live_total <= 7'(r_tick_cnt);
                        r_valid      <= 1'b1;
                        r_res_slot   <= 6'b0;
                        r_res_active <= 1'b0;
                        r_res_life   <= 18'b0;
                        for (int k = 0; k < 3; k++) begin
                            r_res_pos[k] <= 32'b0;
                            r_res_vel[k] <= 32'b0;
                        end
                        r_state <= ppi_pkg::S_IDLE;
                    end
                end
                ppi_pkg::S_EMIT: begin
                    r_flags[r_next_slot] <= 1'b1;
                    r_next_slot <= (r_next_slot == ppi_pkg::AW'(ppi_pkg::POOL_SIZE - 1))
                                 ? '0 : r_next_slot + 1'b1;
                    r_valid      <= 1'b1;
                    r_res_slot   <= 6'(r_next_slot);
                    r_res_active <= 1'b0;
                    r_res_life   <= 18'b0;
                    for (int k = 0; k < 3; k++) begin
                        r_res_pos[k] <= 32'b0;
                        r_res_vel[k] <= 32'b0;
                    end
                    r_state <= ppi_pkg::S_IDLE;
                end
                ppi_pkg::S_READ: begin
                    r_valid    <= 1'b1;
                    r_res_slot <= r_rd_slot;
                    if (r_rd_in_range && r_flags[r_rd_addr]) begin
                        r_res_active <= 1'b1;
                        r_res_life   <= r_mem_q.life;
                        for (int k = 0; k < 3; k++) begin
                            r_res_pos[k] <= r_mem_q.pos[k];
                            r_res_vel[k] <= r_mem_q.vel[k];
                        end
                    end else begin
                        r_res_active <= 1'b0;
                        r_res_life   <= 18'b0;
                        for (int k = 0; k < 3; k++) begin
                            r_res_pos[k] <= 32'b0;
                            r_res_vel[k] <= 32'b0;
                        end
                    end
                    r_state <= ppi_pkg::S_IDLE;
                end
                default: r_state <= ppi_pkg::S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result ports
    // ------------------------------------------------------------------
    assign o_valid      = r_valid;
    assign o_live_count = r_live_total;
    assign o_slot_index = r_res_slot;
    assign o_is_active  = r_res_active;
    assign o_life_left  = $signed(r_res_life);
    assign o_out_pos_x  = $signed(r_res_pos[0]);
    assign o_out_pos_y  = $signed(r_res_pos[1]);
    assign o_out_pos_z  = $signed(r_res_pos[2]);
    assign o_out_vel_x  = $signed(r_res_vel[0]);
    assign o_out_vel_y  = $signed(r_res_vel[1]);
    assign o_out_vel_z  = $signed(r_res_vel[2]);

endmodule : particle_pool_integrator

`default_nettype wire
